[src/usb_control_transfer_td_generator_defines.svh]
// ----------------------------------------------------------------------------
// USB control transfer TD generator: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_TRANSFER_TD_GENERATOR_DEFINES_SVH
`define USB_CONTROL_TRANSFER_TD_GENERATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TDG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("usb td generator check failed");

// consequent must hold in the cycle after the antecedent
`define TDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("usb td generator check failed");

`endif

[src/usbctd_pkg.sv]
// ----------------------------------------------------------------------------
// usbctd_pkg
// Constants, codes and types shared by the control transfer TD generator.
// ----------------------------------------------------------------------------
package usbctd_pkg;

    localparam int DESCRIPTOR_POOL = 64;
    // data descriptors that fit next to the setup and status descriptors
    localparam int POOL_CHUNKS     = DESCRIPTOR_POOL - 2;
    localparam int PROD_W          = 8 + $clog2(DESCRIPTOR_POOL);
    localparam int CMP_W           = (PROD_W > 16) ? PROD_W : 16;

    localparam logic [1:0] STAGE_SETUP  = 2'd0;
    localparam logic [1:0] STAGE_DATA   = 2'd1;
    localparam logic [1:0] STAGE_STATUS = 2'd2;

    localparam logic [7:0] PID_IN          = 8'h69;
    localparam logic [7:0] PID_OUT         = 8'hE1;
    localparam logic [7:0] PID_SETUP_TOKEN = 8'h2D;

    localparam logic [10:0] LEN_SETUP_M1 = 11'd7;
    localparam logic [10:0] LEN_NONE     = 11'h7FF;
    localparam logic [1:0]  ERR_COUNT    = 2'd3;

    typedef struct packed {
        logic [1:0]  stage;
        logic [7:0]  pid;
        logic        toggle;
        logic [10:0] len_m1;
        logic        ioc;
    } td_req_t;

endpackage

[src/usbctd_fmt.sv]
// ----------------------------------------------------------------------------
// usbctd_fmt
// Packs a descriptor request into the TD token and control/status words.
// ----------------------------------------------------------------------------
module usbctd_fmt (
    input  usbctd_pkg::td_req_t req,
    input  logic [6:0]          device_address,
    input  logic                ls_device,
    output logic [31:0]         token_word,
    output logic [31:0]         cs_word
);
    import usbctd_pkg::*;

    // endpoint field (18:15) is always zero
    assign token_word = {req.len_m1, 1'b0, req.toggle, 4'b0000, device_address, req.pid};

    // active 23, ioc 24, low speed 26, error count 28:27
    assign cs_word = {3'b000, ERR_COUNT, ls_device, 1'b0, req.ioc, 1'b1, 23'd0};

endmodule

[src/usb_control_transfer_td_generator.sv]
// ----------------------------------------------------------------------------
// usb_control_transfer_td_generator
// Turns one USB control request into its SETUP, DATA and STATUS TDs.
// ----------------------------------------------------------------------------
// A request is taken only when the block is idle. It first runs its checks
// (pool fit via one multiply of max_packet_size in S_MUL, then a compare in
// S_CHECK) and then loads one descriptor per cycle into the output register
// while the sink takes them: chunks+2 descriptors, or a single error
// descriptor for a refused request. Data chunks are cut by one shared
// subtractor, one chunk per cycle while the sink takes them. The block
// returns to idle as the last descriptor is loaded into the output register,
// so a new request is not taken before the last one is through; it can be
// accepted in the following cycle.
module usb_control_transfer_td_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [6:0]  s_device_address,
    input  logic [7:0]  s_max_packet_size,
    input  logic        s_low_speed_device,
    input  logic        s_direction_in,
    input  logic [15:0] s_data_length,
    input  logic [31:0] s_setup_address,
    input  logic [31:0] s_data_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_stage,
    output logic [31:0] m_token_word,
    output logic [31:0] m_control_status_word,
    output logic [31:0] m_buffer_pointer,
    output logic        m_last_descriptor,
    output logic        m_request_error
);
    import usbctd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_ERR    = 3'd3;
    localparam logic [2:0] S_SETUP  = 3'd4;
    localparam logic [2:0] S_DATA   = 3'd5;
    localparam logic [2:0] S_STATUS = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        avail_reg, avail_next;

    logic [6:0]  addr_reg, addr_next;
    logic [7:0]  mp_reg, mp_next;
    logic        low_reg, low_next;
    logic        dir_reg, dir_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] setup_reg, setup_next;
    logic [31:0] ptr_reg, ptr_next;
    logic        toggle_reg, toggle_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_stage_reg, m_stage_next;
    logic [31:0] m_token_reg, m_token_next;
    logic [31:0] m_cs_reg, m_cs_next;
    logic [31:0] m_buf_reg, m_buf_next;
    logic        m_last_reg, m_last_next;
    logic        m_err_reg, m_err_next;

    td_req_t     req;
    logic [31:0] fmt_token;
    logic [31:0] fmt_cs;
    logic        load;
    logic [16:0] diff;
    logic        borrow;
    logic [7:0]  chunk;
    logic [15:0] rem_after;
    logic        refuse;

    usbctd_fmt u_fmt (
        .req            (req),
        .device_address (addr_reg),
        .ls_device      (low_reg),
        .token_word     (fmt_token),
        .cs_word        (fmt_cs)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign load    = !m_valid_reg || m_ready;

    // shared subtractor: remaining minus max packet, borrow picks the chunk
    assign diff      = {1'b0, rem_reg} - {9'd0, mp_reg};
    assign borrow    = diff[16];
    assign chunk     = borrow ? rem_reg[7:0] : mp_reg;
    assign rem_after = borrow ? 16'd0 : diff[15:0];

    // ceil(len/mp) > POOL_CHUNKS  <=>  len > POOL_CHUNKS*mp
    assign refuse = !avail_reg || (mp_reg == 8'd0)
                    || (CMP_W'(len_reg) > CMP_W'(prod_reg));

    always_comb begin
        req = '0;
        case (state_reg)
            S_SETUP: begin
                req.stage  = STAGE_SETUP;
                req.pid    = PID_SETUP_TOKEN;
                req.len_m1 = LEN_SETUP_M1;
            end
            S_DATA: begin
                req.stage  = STAGE_DATA;
                req.pid    = dir_reg ? PID_IN : PID_OUT;
                req.toggle = toggle_reg;
                req.len_m1 = {3'd0, chunk - 8'd1};
            end
            S_STATUS: begin
                req.stage  = STAGE_STATUS;
                req.pid    = ((len_reg != 16'd0) && dir_reg) ? PID_OUT : PID_IN;
                req.toggle = 1'b1;
                req.len_m1 = LEN_NONE;
                req.ioc    = 1'b1;
            end
            default: req = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        avail_next   = cfg_wr_en ? cfg_wr_data : avail_reg;
        addr_next    = addr_reg;
        mp_next      = mp_reg;
        low_next     = low_reg;
        dir_next     = dir_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        setup_next   = setup_reg;
        ptr_next     = ptr_reg;
        toggle_next  = toggle_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_stage_next = m_stage_reg;
        m_token_next = m_token_reg;
        m_cs_next    = m_cs_reg;
        m_buf_next   = m_buf_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    addr_next  = s_device_address;
                    mp_next    = s_max_packet_size;
                    low_next   = s_low_speed_device;
                    dir_next   = s_direction_in;
                    len_next   = s_data_length;
                    rem_next   = s_data_length;
                    setup_next = s_setup_address;
                    ptr_next   = s_data_address;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(mp_reg) * PROD_W'(POOL_CHUNKS);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = refuse ? S_ERR : S_SETUP;
            end
            S_ERR: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_stage_next = STAGE_SETUP;
                    m_token_next = '0;
                    m_cs_next    = '0;
                    m_buf_next   = '0;
                    m_last_next  = 1'b1;
                    m_err_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SETUP: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_stage_next = req.stage;
                    m_token_next = fmt_token;
                    m_cs_next    = fmt_cs;
                    m_buf_next   = setup_reg;
                    m_last_next  = 1'b0;
                    m_err_next   = 1'b0;
                    toggle_next  = 1'b1;
                    state_next   = (len_reg != 16'd0) ? S_DATA : S_STATUS;
                end
            end
            S_DATA: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_stage_next = req.stage;
                    m_token_next = fmt_token;
                    m_cs_next    = fmt_cs;
                    m_buf_next   = ptr_reg;
                    m_last_next  = 1'b0;
                    m_err_next   = 1'b0;
                    ptr_next     = ptr_reg + {24'd0, chunk};
                    rem_next     = rem_after;
                    toggle_next  = !toggle_reg;
                    if (rem_after == 16'd0) begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_STATUS: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_stage_next = req.stage;
                    m_token_next = fmt_token;
                    m_cs_next    = fmt_cs;
                    m_buf_next   = '0;
                    m_last_next  = 1'b1;
                    m_err_next   = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            avail_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            avail_reg   <= avail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        mp_reg      <= mp_next;
        low_reg     <= low_next;
        dir_reg     <= dir_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        setup_reg   <= setup_next;
        ptr_reg     <= ptr_next;
        toggle_reg  <= toggle_next;
        prod_reg    <= prod_next;
        m_stage_reg <= m_stage_next;
        m_token_reg <= m_token_next;
        m_cs_reg    <= m_cs_next;
        m_buf_reg   <= m_buf_next;
        m_last_reg  <= m_last_next;
        m_err_reg   <= m_err_next;
    end

    assign m_valid               = m_valid_reg;
    assign m_stage               = m_stage_reg;
    assign m_token_word          = m_token_reg;
    assign m_control_status_word = m_cs_reg;
    assign m_buffer_pointer      = m_buf_reg;
    assign m_last_descriptor     = m_last_reg;
    assign m_request_error       = m_err_reg;

`include "usb_control_transfer_td_generator_defines.svh"

    `TDG_ASSERT_SAME(a_err_is_last, m_valid && m_request_error, m_last_descriptor && (m_token_word == 32'd0))
    `TDG_ASSERT_SAME(a_status_last, m_valid && (m_stage == STAGE_STATUS), m_last_descriptor && m_control_status_word[24])
    `TDG_ASSERT_SAME(a_data_rem, state_reg == S_DATA, rem_reg != 16'd0)
    `TDG_ASSERT_NEXT(a_one_request, s_valid && s_ready, !s_ready)

endmodule
